// ===== rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg: shared types and constants for the prefix/suffix delta codec
// Transaction payloads, command kinds, sequencer states and field widths.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int BYTE_W        = 8;
   localparam int IDX_W         = 12;
   localparam int LEN_W         = 13;
   // Wide enough for prefix + index and for the wrapped suffix offset.
   localparam int PTR_W         = 14;
   localparam int DEF_MAX_BYTES = 4096;

   typedef enum logic [2:0] {
      KIND_WR_PREV = 3'd0,
      KIND_WR_NEW  = 3'd1,
      KIND_ENCODE  = 3'd2,
      KIND_RD_DELTA = 3'd3,
      KIND_RD_REST = 3'd4
   } psd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PFX,
      ST_SFX,
      ST_FIN,
      ST_READ,
      ST_DONE
   } psd_state_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_PREV,
      SRC_NEW
   } psd_src_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [IDX_W-1:0]  index;
      logic [BYTE_W-1:0] data_in;
      logic [LEN_W-1:0]  previous_length;
      logic [LEN_W-1:0]  new_length;
   } psd_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              identical;
      logic [LEN_W-1:0]  prefix_count;
      logic [LEN_W-1:0]  suffix_count;
      logic [LEN_W-1:0]  delta_length;
      logic              out_of_range;
   } psd_rsp_type;

endpackage

// ===== rtl/psd_store.sv =====
// ----------------------------------------------------------------------------
// psd_store: snapshot byte memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psd_store #(
   parameter int DEPTH = psd_pkg::DEF_MAX_BYTES,
   parameter int AW    = $clog2(psd_pkg::DEF_MAX_BYTES)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [psd_pkg::BYTE_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [psd_pkg::BYTE_W-1:0] rd_data
);
   import psd_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psd_ctrl.sv =====
// ----------------------------------------------------------------------------
// psd_ctrl: command sequencer for the delta codec
// Decodes transactions, walks both stores with one shared byte compare and
// counter during encode, and keeps the stored prefix, suffix and delta state.
// ----------------------------------------------------------------------------
module psd_ctrl #(
   parameter int MAX_BYTES = psd_pkg::DEF_MAX_BYTES,
   parameter int AW        = $clog2(psd_pkg::DEF_MAX_BYTES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  psd_pkg::psd_req_type        req_data,
   input  logic                        out_free,
   output logic                        res_valid,
   output psd_pkg::psd_rsp_type        res_data,
   output logic                        prev_wr_en,
   output logic                        new_wr_en,
   output logic [AW-1:0]               wr_addr,
   output logic [psd_pkg::BYTE_W-1:0]  wr_data,
   output logic [AW-1:0]               prev_rd_addr,
   output logic [AW-1:0]               new_rd_addr,
   input  logic [psd_pkg::BYTE_W-1:0]  prev_rd_data,
   input  logic [psd_pkg::BYTE_W-1:0]  new_rd_data
);
   import psd_pkg::*;

   localparam int PW = (AW > PTR_W) ? AW : PTR_W;

   psd_state_type     state_ff, state_in;
   psd_src_type       src_ff, src_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  nlen_ff, nlen_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  lim_ff, lim_in;
   logic [PW-1:0]     pp_ff, pp_in;
   logic [PW-1:0]     np_ff, np_in;
   logic [LEN_W-1:0]  prefix_ff, prefix_in;
   logic [LEN_W-1:0]  suffix_ff, suffix_in;
   logic [LEN_W-1:0]  delta_ff, delta_in;
   logic [LEN_W-1:0]  mid_ff, mid_in;
   logic [LEN_W-1:0]  total_ff, total_in;
   logic [PW-1:0]     sbase_ff, sbase_in;
   logic              ident_ff, ident_in;
   logic              oor_ff, oor_in;
   logic [BYTE_W-1:0] rdata_ff, rdata_in;

   logic [LEN_W-1:0]  req_plen;
   logic [LEN_W-1:0]  req_nlen;
   logic [LEN_W-1:0]  req_idx;
   logic [LEN_W-1:0]  remain;
   logic [PW-1:0]     idx_ptr;
   logic              idx_ok;
   logic              bytes_eq;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] r;
      r = v;
      if (32'(v) > 32'(MAX_BYTES)) begin
         r = LEN_W'(MAX_BYTES);
      end
      return r;
   endfunction

   assign req_plen = clamp_len(req_data.previous_length);
   assign req_nlen = clamp_len(req_data.new_length);
   assign req_idx  = LEN_W'(req_data.index);
   assign idx_ptr  = PW'(req_data.index);
   assign idx_ok   = 32'(req_data.index) < 32'(MAX_BYTES);
   assign bytes_eq = prev_rd_data == new_rd_data;
   assign remain   = nlen_ff - cnt_ff;

   assign wr_addr      = idx_ptr[AW-1:0];
   assign wr_data      = req_data.data_in;
   assign prev_rd_addr = pp_in[AW-1:0];
   assign new_rd_addr  = np_in[AW-1:0];

   assign res_data.data_out     = rdata_ff;
   assign res_data.identical    = ident_ff;
   assign res_data.prefix_count = prefix_ff;
   assign res_data.suffix_count = suffix_ff;
   assign res_data.delta_length = delta_ff;
   assign res_data.out_of_range = oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prefix_ff <= '0;
         suffix_ff <= '0;
         delta_ff  <= '0;
         mid_ff    <= '0;
         total_ff  <= '0;
         sbase_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         prefix_ff <= prefix_in;
         suffix_ff <= suffix_in;
         delta_ff  <= delta_in;
         mid_ff    <= mid_in;
         total_ff  <= total_in;
         sbase_ff  <= sbase_in;
      end
      src_ff   <= src_in;
      plen_ff  <= plen_in;
      nlen_ff  <= nlen_in;
      cnt_ff   <= cnt_in;
      lim_ff   <= lim_in;
      pp_ff    <= pp_in;
      np_ff    <= np_in;
      ident_ff <= ident_in;
      oor_ff   <= oor_in;
      rdata_ff <= rdata_in;
   end

   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      plen_in    = plen_ff;
      nlen_in    = nlen_ff;
      cnt_in     = cnt_ff;
      lim_in     = lim_ff;
      pp_in      = pp_ff;
      np_in      = np_ff;
      prefix_in  = prefix_ff;
      suffix_in  = suffix_ff;
      delta_in   = delta_ff;
      mid_in     = mid_ff;
      total_in   = total_ff;
      sbase_in   = sbase_ff;
      ident_in   = ident_ff;
      oor_in     = oor_ff;
      rdata_in   = rdata_ff;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      prev_wr_en = 1'b0;
      new_wr_en  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ident_in = 1'b0;
               oor_in   = 1'b0;
               rdata_in = '0;
               src_in   = SRC_NONE;
               state_in = ST_DONE;
               unique case (req_data.kind)
                  KIND_WR_PREV: prev_wr_en = idx_ok;
                  KIND_WR_NEW:  new_wr_en = idx_ok;
                  KIND_ENCODE: begin
                     plen_in  = req_plen;
                     nlen_in  = req_nlen;
                     lim_in   = (req_plen < req_nlen) ? req_plen : req_nlen;
                     cnt_in   = '0;
                     pp_in    = '0;
                     np_in    = '0;
                     state_in = ST_PFX;
                  end
                  KIND_RD_DELTA: begin
                     np_in    = PW'(prefix_ff) + idx_ptr;
                     state_in = ST_READ;
                     if (req_idx < delta_ff) begin
                        src_in = SRC_NEW;
                     end else begin
                        oor_in = 1'b1;
                     end
                  end
                  KIND_RD_REST: begin
                     state_in = ST_READ;
                     np_in    = idx_ptr;
                     if (req_idx < prefix_ff) begin
                        src_in = SRC_PREV;
                        pp_in  = idx_ptr;
                     end else if (req_idx < mid_ff) begin
                        src_in = SRC_NEW;
                     end else if (req_idx < total_ff) begin
                        src_in = SRC_PREV;
                        pp_in  = sbase_ff + idx_ptr;
                     end else begin
                        oor_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Read data for pointer cnt_ff arrives now; the next pointer is issued
         // in the same cycle, so the walk covers one byte per cycle.
         ST_PFX: begin
            if (cnt_ff < lim_ff && bytes_eq) begin
               cnt_in = cnt_ff + 1'b1;
               pp_in  = pp_ff + 1'b1;
               np_in  = np_ff + 1'b1;
            end else begin
               prefix_in = cnt_ff;
               ident_in  = (plen_ff == nlen_ff) && (cnt_ff == nlen_ff);
               // No suffix walk when either snapshot is a prefix of the other.
               if (cnt_ff == nlen_ff || cnt_ff == plen_ff) begin
                  lim_in = '0;
               end else begin
                  lim_in = (plen_ff < remain) ? plen_ff : remain;
               end
               cnt_in   = '0;
               pp_in    = PW'(plen_ff) - 1'b1;
               np_in    = PW'(nlen_ff) - 1'b1;
               state_in = ST_SFX;
            end
         end

         ST_SFX: begin
            if (cnt_ff < lim_ff && bytes_eq) begin
               cnt_in = cnt_ff + 1'b1;
               pp_in  = pp_ff - 1'b1;
               np_in  = np_ff - 1'b1;
            end else begin
               suffix_in = cnt_ff;
               mid_in    = nlen_ff - cnt_ff;
               total_in  = nlen_ff;
               // Suffix bytes of the old snapshot start at index - (new - old).
               sbase_in  = PW'(plen_ff) - PW'(nlen_ff);
               state_in  = ST_FIN;
            end
         end

         ST_FIN: begin
            delta_in = mid_ff - prefix_ff;
            state_in = ST_DONE;
         end

         ST_READ: begin
            case (src_ff)
               SRC_PREV: rdata_in = prev_rd_data;
               SRC_NEW:  rdata_in = new_rd_data;
               default:  rdata_in = '0;
            endcase
            state_in = ST_DONE;
         end

         ST_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/prefix_suffix_delta_codec.sv =====
// ----------------------------------------------------------------------------
// prefix_suffix_delta_codec: snapshot delta encoder and restorer
// Two byte stores, a sequencer that finds the common prefix and suffix, and
// an output register toward the result channel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data  (psd_req_type)
//  rsp      out        rsp_valid / rsp_ready  rsp_data  (psd_rsp_type)
//
//  From acceptance to the result register: writes and unknown kinds go straight
//  to the result, reads pass through the read state, and encode walks the
//  matched prefix, then the matched suffix, then a finish state; the walk
//  compares one byte pair per cycle. The sequencer accepts again in the cycle
//  after its result is registered, even if that result still waits on rsp, and
//  a stalled rsp holds it in its final step. Reset clears the stored counts;
//  store contents are undefined until written.
module prefix_suffix_delta_codec #(
   parameter int MAX_BYTES = psd_pkg::DEF_MAX_BYTES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  psd_pkg::psd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output psd_pkg::psd_rsp_type rsp_data
);
   import psd_pkg::*;

   localparam int AW = $clog2(MAX_BYTES);

   logic              out_free;
   logic              res_valid;
   psd_rsp_type       res_data;
   logic              prev_wr_en;
   logic              new_wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [AW-1:0]     prev_rd_addr;
   logic [AW-1:0]     new_rd_addr;
   logic [BYTE_W-1:0] prev_rd_data;
   logic [BYTE_W-1:0] new_rd_data;
   logic              rsp_valid_ff;
   psd_rsp_type       rsp_data_ff;

   psd_ctrl #(
      .MAX_BYTES(MAX_BYTES),
      .AW       (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res_data    (res_data),
      .prev_wr_en  (prev_wr_en),
      .new_wr_en   (new_wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .prev_rd_addr(prev_rd_addr),
      .new_rd_addr (new_rd_addr),
      .prev_rd_data(prev_rd_data),
      .new_rd_data (new_rd_data)
   );

   psd_store #(
      .DEPTH(MAX_BYTES),
      .AW   (AW)
   ) u_prev_store (
      .clock  (clock),
      .wr_en  (prev_wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(prev_rd_addr),
      .rd_data(prev_rd_data)
   );

   psd_store #(
      .DEPTH(MAX_BYTES),
      .AW   (AW)
   ) u_new_store (
      .clock  (clock),
      .wr_en  (new_wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(new_rd_addr),
      .rd_data(new_rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid && out_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The sequencer is busy in the cycle after every accepted transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // Only encode reports identical, only reads report out of range.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.identical && rsp_data.out_of_range))
      else $error("identical and out_of_range both set");

   a_identical_no_delta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.identical |->
         rsp_data.suffix_count == '0 && rsp_data.delta_length == '0)
      else $error("identical encode left a suffix or delta");

   a_oor_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.data_out == '0)
      else $error("out of range read returned data");

endmodule

// ===== tb/prefix_suffix_delta_codec_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_suffix_delta_codec_tb: self-checking bench for the snapshot delta codec
// Loads snapshot pairs, encodes them and reads back delta and restored bytes,
// predicting every response and comparing it field by field under random
// idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module prefix_suffix_delta_codec_tb;
   import psd_pkg::*;

   localparam int          STORE_BYTES  = DEF_MAX_BYTES;
   localparam int          FILL_BYTES   = 64;
   localparam int          CYCLE_LIMIT  = 5_000_000;
   localparam int          SETTLE_WAIT  = 64;
   localparam int          PHASE_ITEMS  = 360;
   localparam int          HOLD_CYCLES  = 400;
   localparam logic [2:0]  KIND_RSVD_LO = 3'd5;
   localparam logic [2:0]  KIND_RSVD_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   psd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   psd_rsp_type rsp_data;

   // Predicted copy of the block's state.
   logic [7:0]  prev_snapshot [0:STORE_BYTES-1];
   logic [7:0]  new_snapshot  [0:STORE_BYTES-1];
   int unsigned matched_prefix;
   int unsigned matched_suffix;
   int unsigned delta_bytes;
   int unsigned encoded_prev_len;

   psd_rsp_type pending_codec_results [$];
   psd_rsp_type oldest_result;
   int          error_count;
   int          requests_sent;
   int          cycle_count;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          hold_off_left;

   prefix_suffix_delta_codec u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic int unsigned clamp_length(input logic [LEN_W-1:0] len);
      return (len > STORE_BYTES) ? STORE_BYTES : int'(len);
   endfunction

   // Applies one transaction to the predicted state and returns its response.
   function automatic psd_rsp_type codec_result_for(input psd_req_type item);
      psd_rsp_type res;
      int unsigned plen, nlen, shorter, p, s, mid, idx;
      res = '0;
      idx = item.index;
      case (item.kind)
         KIND_WR_PREV: prev_snapshot[idx] = item.data_in;
         KIND_WR_NEW:  new_snapshot[idx] = item.data_in;
         KIND_ENCODE: begin
            plen = clamp_length(item.previous_length);
            nlen = clamp_length(item.new_length);
            shorter = (plen < nlen) ? plen : nlen;
            p = 0;
            s = 0;
            while (p < shorter && prev_snapshot[p] == new_snapshot[p]) p++;
            matched_prefix = p;
            matched_suffix = 0;
            delta_bytes = 0;
            encoded_prev_len = plen;
            if (plen == nlen && p == nlen) begin
               res.identical = 1'b1;
            end else if (p != nlen) begin
               // The suffix walk is skipped when the old snapshot is a prefix of the new one.
               if (p != plen) begin
                  while (s < plen && s < nlen - p &&
                         prev_snapshot[plen - 1 - s] == new_snapshot[nlen - 1 - s]) s++;
               end
               matched_suffix = s;
               delta_bytes = nlen - p - s;
            end
         end
         KIND_RD_DELTA: begin
            if (idx < delta_bytes) res.data_out = new_snapshot[matched_prefix + idx];
            else res.out_of_range = 1'b1;
         end
         KIND_RD_REST: begin
            mid = matched_prefix + delta_bytes;
            if (idx < matched_prefix) res.data_out = prev_snapshot[idx];
            else if (idx < mid) res.data_out = new_snapshot[idx];
            else if (idx < mid + matched_suffix)
               res.data_out = prev_snapshot[encoded_prev_len - matched_suffix + (idx - mid)];
            else res.out_of_range = 1'b1;
         end
         default: ;
      endcase
      res.prefix_count = matched_prefix[LEN_W-1:0];
      res.suffix_count = matched_suffix[LEN_W-1:0];
      res.delta_length = delta_bytes[LEN_W-1:0];
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Response checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codec_results.size() == 0) begin
            $error("response arrived with no transaction outstanding");
            error_count++;
         end else begin
            oldest_result = pending_codec_results.pop_front();
            check_field("data_out", 16'(oldest_result.data_out), 16'(rsp_data.data_out));
            check_field("identical", 16'(oldest_result.identical), 16'(rsp_data.identical));
            check_field("prefix_count", 16'(oldest_result.prefix_count),
                        16'(rsp_data.prefix_count));
            check_field("suffix_count", 16'(oldest_result.suffix_count),
                        16'(rsp_data.suffix_count));
            check_field("delta_length", 16'(oldest_result.delta_length),
                        16'(rsp_data.delta_length));
            check_field("out_of_range", 16'(oldest_result.out_of_range),
                        16'(rsp_data.out_of_range));
         end
      end
   end

   // Response receiver: random stalls, plus a counted hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_ready <= 1'b0;
            hold_off_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   task automatic send_item(input psd_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_codec_results.push_back(codec_result_for(item));
      requests_sent++;
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_codec_results.size() != 0) @(posedge clock);
   endtask

   // Encode lengths stay within the loaded low part of the stores, so every
   // walk and every later read touches written bytes only.
   function automatic psd_req_type random_item();
      psd_req_type item;
      item.kind            = 3'($urandom_range(7));
      item.index           = IDX_W'($urandom);
      item.data_in         = BYTE_W'($urandom);
      item.previous_length = LEN_W'($urandom_range(FILL_BYTES));
      item.new_length      = LEN_W'($urandom_range(FILL_BYTES));
      return item;
   endfunction

   task automatic write_byte(input psd_kind_type kind, input int index, input logic [7:0] value);
      psd_req_type item;
      item = random_item();
      item.kind    = kind;
      item.index   = index[IDX_W-1:0];
      item.data_in = value;
      send_item(item);
   endtask

   task automatic encode(input int plen, input int nlen);
      psd_req_type item;
      item = random_item();
      item.kind            = KIND_ENCODE;
      item.previous_length = plen[LEN_W-1:0];
      item.new_length      = nlen[LEN_W-1:0];
      send_item(item);
   endtask

   task automatic read_byte(input psd_kind_type kind, input int index);
      psd_req_type item;
      item = random_item();
      item.kind  = kind;
      item.index = index[IDX_W-1:0];
      send_item(item);
   endtask

   task automatic send_odd_kind(input logic [2:0] kind);
      psd_req_type item;
      item = random_item();
      item.kind = kind;
      send_item(item);
   endtask

   function automatic logic [7:0] random_byte(input bit narrow);
      if (narrow) return $urandom_range(1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   // One load, encode and readback sequence with a randomly chosen relation
   // between the two snapshots.
   task automatic run_snapshot_round(input int max_len);
      logic [7:0] old_snap [0:63];
      logic [7:0] new_snap [0:63];
      int         old_len, new_len, shorter, head, tail, shape, reads, idx;
      bit         narrow;
      old_len = $urandom_range(max_len);
      new_len = $urandom_range(max_len);
      shape   = $urandom_range(5);
      narrow  = ($urandom_range(3) == 0);
      for (int i = 0; i < 64; i++) begin
         old_snap[i] = random_byte(narrow);
         new_snap[i] = random_byte(narrow);
      end
      case (shape)
         0: begin
            new_len = old_len;
            for (int i = 0; i < old_len; i++) new_snap[i] = old_snap[i];
         end
         1: begin
            new_len = $urandom_range(old_len);
            for (int i = 0; i < new_len; i++) new_snap[i] = old_snap[i];
         end
         2: begin
            new_len = old_len + $urandom_range(max_len - old_len);
            for (int i = 0; i < old_len; i++) new_snap[i] = old_snap[i];
         end
         3: begin
            shorter = (old_len < new_len) ? old_len : new_len;
            head = $urandom_range(shorter);
            tail = $urandom_range(shorter - head);
            for (int i = 0; i < head; i++) new_snap[i] = old_snap[i];
            for (int k = 0; k < tail; k++)
               new_snap[new_len - tail + k] = old_snap[old_len - tail + k];
         end
         default: ;
      endcase
      if ($urandom_range(3) == 0) send_item(random_item());
      for (int i = 0; i < old_len; i++) write_byte(KIND_WR_PREV, i, old_snap[i]);
      for (int i = 0; i < new_len; i++) write_byte(KIND_WR_NEW, i, new_snap[i]);
      // Now and then the encode is dropped so reads see stale counts.
      if ($urandom_range(7) != 0) encode(old_len, new_len);
      reads = $urandom_range(2, 8);
      for (int r = 0; r < reads; r++) begin
         idx = ($urandom_range(7) == 0) ? $urandom_range(STORE_BYTES - 1)
                                        : $urandom_range(new_len + 2);
         read_byte($urandom_range(1) ? KIND_RD_DELTA : KIND_RD_REST, idx);
      end
      if ($urandom_range(3) == 0) send_item(random_item());
   endtask

   task automatic test_reset_state();
      read_byte(KIND_RD_DELTA, 0);
      read_byte(KIND_RD_REST, STORE_BYTES - 1);
      wait_for_drain();
   endtask

   // Loads the low part of both stores, which every other encode stays within,
   // then saturates both lengths with walks that stop on the first byte pair.
   task automatic test_wide_lengths();
      logic [7:0] value;
      for (int i = 0; i < FILL_BYTES; i++) begin
         value = 8'($urandom);
         write_byte(KIND_WR_PREV, i, value);
         write_byte(KIND_WR_NEW, i, value);
      end
      encode(FILL_BYTES, FILL_BYTES);
      read_byte(KIND_RD_REST, FILL_BYTES - 1);
      read_byte(KIND_RD_DELTA, 0);
      write_byte(KIND_WR_PREV, STORE_BYTES - 1, 8'h5A);
      write_byte(KIND_WR_NEW, STORE_BYTES - 1, 8'hA5);
      write_byte(KIND_WR_NEW, 0, ~prev_snapshot[0]);
      encode(8191, STORE_BYTES + 1);
      read_byte(KIND_RD_DELTA, 0);
      read_byte(KIND_RD_DELTA, STORE_BYTES - 1);
      read_byte(KIND_RD_REST, 0);
      read_byte(KIND_RD_REST, STORE_BYTES - 1);
      // Bring the stored counts back inside the loaded bytes.
      encode(FILL_BYTES, FILL_BYTES);
      read_byte(KIND_RD_DELTA, 0);
      read_byte(KIND_RD_REST, FILL_BYTES - 1);
      wait_for_drain();
   endtask

   task automatic test_special_cases();
      write_byte(KIND_WR_PREV, 0, 8'h00);
      write_byte(KIND_WR_PREV, 1, 8'hFF);
      write_byte(KIND_WR_PREV, 2, 8'h00);
      write_byte(KIND_WR_NEW, 0, 8'h00);
      write_byte(KIND_WR_NEW, 1, 8'hFF);
      write_byte(KIND_WR_NEW, 2, 8'hFF);
      write_byte(KIND_WR_NEW, 3, 8'h00);
      // The suffix reuses an old byte that is also part of the prefix.
      encode(3, 4);
      for (int i = 0; i <= 4; i++) read_byte(KIND_RD_REST, i);
      read_byte(KIND_RD_DELTA, 0);
      encode(2, 4);
      read_byte(KIND_RD_DELTA, 0);
      read_byte(KIND_RD_DELTA, 1);
      encode(3, 2);
      encode(0, 0);
      send_odd_kind(KIND_RSVD_LO);
      send_odd_kind(KIND_RSVD_HI);
      wait_for_drain();
   endtask

   task automatic test_random_rounds();
      int sender_pcts   [4] = '{0, 67, 0, 12};
      int receiver_pcts [4] = '{0, 0, 67, 12};
      int start_count;
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = sender_pcts[phase];
         receiver_stall_pct = receiver_pcts[phase];
         start_count        = requests_sent;
         while (requests_sent - start_count < PHASE_ITEMS)
            run_snapshot_round(($urandom_range(7) == 0) ? 64 : 16);
         wait_for_drain();
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   // The receiver holds off while requests keep coming, so the block backs up.
   task automatic test_output_backpressure();
      hold_off_left = HOLD_CYCLES;
      run_snapshot_round(16);
      run_snapshot_round(16);
      wait_for_drain();
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      error_count        = 0;
      requests_sent      = 0;
      cycle_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_wide_lengths();
      test_special_cases();
      test_random_rounds();
      test_output_backpressure();
      wait_for_drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      if (error_count == 0 && pending_codec_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
